@@ hdl/rms_pkg.sv @@
// Shared types, constants and helpers for the rate monotonic task scheduler.
package rms_pkg;

  localparam int unsigned SLOTS         = 4;
  localparam int unsigned NUM_TASKS_DEF = 4;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned PERIOD_W      = 16;
  localparam int unsigned BUDGET_W      = 8;
  localparam int unsigned TASK_IDX_W    = 2;
  localparam int unsigned RUN_W         = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned APB_ADDR_W    = 5;
  localparam int unsigned REG_IDX_W     = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [REG_IDX_W-1:0] REG_PERIOD_BASE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BUDGET_BASE = 3'd4;

  localparam logic [RUN_W-1:0] RUN_IDLE = 3'd0;

  typedef struct packed {
    logic [SLOTS-1:0][PERIOD_W-1:0] period;
    logic [SLOTS-1:0][BUDGET_W-1:0] budget;
  } cfg_t;

  typedef struct packed {
    logic [RUN_W-1:0]  task_run;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] time_now;
    logic              time_saturated;
  } res_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

@@ hdl/rms_cfg_regs.sv @@
// APB register file holding the task periods and budgets.
module rms_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rms_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [rms_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [rms_pkg::APB_DATA_W-1:0]      prdata,
  output rms_pkg::cfg_t                       cfg_o
);

  rms_pkg::cfg_t                       cfg_q, cfg_d;
  logic [rms_pkg::REG_IDX_W-1:0]       idx;
  logic [rms_pkg::TASK_IDX_W-1:0]      slot;
  logic                                wr_en;

  assign idx   = paddr[rms_pkg::APB_ADDR_W-1:2];
  assign slot  = idx[rms_pkg::TASK_IDX_W-1:0];
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (idx < rms_pkg::REG_BUDGET_BASE) begin
        cfg_d.period[slot] = pwdata[rms_pkg::PERIOD_W-1:0];
      end else begin
        cfg_d.budget[slot] = pwdata[rms_pkg::BUDGET_W-1:0];
      end
    end
  end

  always_comb begin
    if (idx < rms_pkg::REG_BUDGET_BASE) begin
      prdata = {{(rms_pkg::APB_DATA_W-rms_pkg::PERIOD_W){1'b0}}, cfg_q.period[slot]};
    end else begin
      prdata = {{(rms_pkg::APB_DATA_W-rms_pkg::BUDGET_W){1'b0}}, cfg_q.budget[slot]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rms_pkg::SLOTS; i++) begin
        cfg_q.period[i] <= rms_pkg::PERIOD_W'(1);
        cfg_q.budget[i] <= rms_pkg::BUDGET_W'(1);
      end
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/rms_core.sv @@
// Scheduler state and single-pass step logic: restart, pick, run, reload, idle jump.
module rms_core #(
  parameter int unsigned NUM_TASKS = rms_pkg::NUM_TASKS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          restart_i,
  input  rms_pkg::cfg_t cfg_i,
  output rms_pkg::res_t res_o
);

  logic [rms_pkg::BUDGET_W-1:0] rem_q [NUM_TASKS];
  logic [rms_pkg::BUDGET_W-1:0] rem_d [NUM_TASKS];
  logic [rms_pkg::TIME_W-1:0]   rel_q [NUM_TASKS];
  logic [rms_pkg::TIME_W-1:0]   rel_d [NUM_TASKS];
  logic [rms_pkg::TIME_W-1:0]   time_q, time_d;

  logic                           found;
  logic [rms_pkg::PERIOD_W-1:0]   best;
  logic [rms_pkg::TASK_IDX_W-1:0] pick;
  logic                           soon_found;
  logic [rms_pkg::TIME_W-1:0]     soon;
  logic [rms_pkg::BUDGET_W-1:0]   rem_dec;
  logic                           sat;

  // Shortest period among released tasks with budget left; ties keep lower index.
  always_comb begin
    found = 1'b0;
    best  = '0;
    pick  = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (rem_q[i] != '0 && rel_q[i] <= time_q) begin
        if (!found || cfg_i.period[i] < best) begin
          found = 1'b1;
          best  = cfg_i.period[i];
          pick  = rms_pkg::TASK_IDX_W'(i);
        end
      end
    end
  end

  // Earliest release strictly after now.
  always_comb begin
    soon_found = 1'b0;
    soon       = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (rel_q[i] > time_q && (!soon_found || rel_q[i] < soon)) begin
        soon_found = 1'b1;
        soon       = rel_q[i];
      end
    end
  end

  always_comb begin
    rem_dec = '0;
    time_d  = time_q;
    for (int i = 0; i < NUM_TASKS; i++) begin
      rem_d[i] = rem_q[i];
      rel_d[i] = rel_q[i];
    end
    if (restart_i) begin
      time_d = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        rem_d[i] = cfg_i.budget[i];
        rel_d[i] = '0;
      end
    end else if (found) begin
      time_d = rms_pkg::sat_add(time_q, rms_pkg::TIME_W'(1));
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (pick == rms_pkg::TASK_IDX_W'(i)) begin
          rem_dec = rem_q[i] - rms_pkg::BUDGET_W'(1);
          if (rem_dec == '0) begin
            rem_d[i] = cfg_i.budget[i];
            rel_d[i] = rms_pkg::sat_add(rel_q[i],
                         {{(rms_pkg::TIME_W-rms_pkg::PERIOD_W){1'b0}}, cfg_i.period[i]});
          end else begin
            rem_d[i] = rem_dec;
          end
        end
      end
    end else if (soon_found) begin
      time_d = soon;
    end
  end

  always_comb begin
    sat = (time_d == rms_pkg::TIME_MAX);
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (rel_d[i] == rms_pkg::TIME_MAX) begin
        sat = 1'b1;
      end
    end
  end

  always_comb begin
    if (restart_i) begin
      res_o.task_run       = rms_pkg::RUN_IDLE;
      res_o.span           = '0;
      res_o.time_now       = '0;
      res_o.time_saturated = 1'b0;
    end else begin
      res_o.task_run       = found ? ({1'b0, pick} + rms_pkg::RUN_W'(1)) : rms_pkg::RUN_IDLE;
      res_o.span           = time_d - time_q;
      res_o.time_now       = time_d;
      res_o.time_saturated = sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        rem_q[i] <= '0;
        rel_q[i] <= '0;
      end
    end else if (step_i) begin
      time_q <= time_d;
      for (int i = 0; i < NUM_TASKS; i++) begin
        rem_q[i] <= rem_d[i];
        rel_q[i] <= rel_d[i];
      end
    end
  end

endmodule

@@ hdl/rate_monotonic_task_scheduler.sv @@
// Top level of the rate monotonic task scheduler: handshake stages, core, registers.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o   | restart_i
//   out     | output    | out_valid_o / out_stall_i | task_run_o, span_o, time_now_o,
//           |           |                           | time_saturated_o
//   cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One transaction per cycle sustained when the output does not stall; order: input
// register, then the step logic feeding the result register, which also updates the
// schedule state. Reset clears the schedule state and sets every period and budget to 1.
// An output stall holds the result and the input register together; in_stall_o follows.
module rate_monotonic_task_scheduler #(
  parameter int unsigned NUM_TASKS = rms_pkg::NUM_TASKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rms_pkg::RUN_W-1:0]      task_run_o,
  output logic [rms_pkg::TIME_W-1:0]     span_o,
  output logic [rms_pkg::TIME_W-1:0]     time_now_o,
  output logic                           time_saturated_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rms_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rms_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rms_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  rms_pkg::cfg_t cfg;
  rms_pkg::res_t res, res_q;
  logic          s1_valid_q, s1_restart_q;
  logic          out_valid_q;
  logic          adv, step;

  assign pready = 1'b1;

  rms_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign adv        = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;

  rms_core #(
    .NUM_TASKS (NUM_TASKS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .restart_i (s1_restart_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_restart_q <= restart_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign task_run_o       = res_q.task_run;
  assign span_o           = res_q.span;
  assign time_now_o       = res_q.time_now;
  assign time_saturated_o = res_q.time_saturated;

`ifndef SYNTHESIS
  a_run_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && task_run_o != rms_pkg::RUN_IDLE |-> span_o <= rms_pkg::TIME_W'(1))
    else $error("run result advanced time by more than one tick");

  a_run_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> task_run_o <= rms_pkg::RUN_W'(NUM_TASKS))
    else $error("task number beyond configured task count");

  a_restart_res : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && s1_restart_q |=> out_valid_o && time_now_o == '0 && span_o == '0
      && task_run_o == rms_pkg::RUN_IDLE && !time_saturated_o)
    else $error("restart transaction did not return a cleared result");
`endif

endmodule
